### src/ikhm_pkg.sv
// shared types and constants for the sorted-bucket integer map
package ikhm_pkg;

  localparam logic [31:0] MIX_PRIME = 32'h27d4eb2d;
  localparam logic [31:0] MIX_XOR   = 32'd61;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_UNIQUE = 2'd1,
    OP_FIND   = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EXISTS  = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH2,
    S_HASH3,
    S_FILL_WAIT,
    S_SCAN,
    S_SCAN_WAIT,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  // signed compare of two key words, true when a is below b
  function automatic logic key_less(input logic [31:0] a, input logic [31:0] b);
    key_less = $signed(a) < $signed(b);
  endfunction

endpackage

### src/ikhm_hash.sv
// multi-cycle integer mix of a key into a bucket hash
module ikhm_hash import ikhm_pkg::*; (
  input  logic        clk,
  input  logic        start,
  input  logic [31:0] key,
  output logic [31:0] hash
);
  logic [31:0] h1;
  logic [31:0] h2;
  logic [31:0] t0;
  logic [31:0] t1;
  logic [31:0] prod;

  always_comb begin
    t0 = (key ^ MIX_XOR) ^ 32'($signed(key) >>> 16);
    t0 = t0 + (t0 << 3);
    t1 = t0 ^ 32'($signed(t0) >>> 4);
  end

  // stage one: shifts and adds, stage two: multiply, then final fold
  always_ff @(posedge clk) begin
    if (start) begin
      h1 <= t1;
    end
    prod <= h1 * MIX_PRIME;
  end

  always_comb begin
    h2   = prod ^ 32'($signed(prod) >>> 15);
    hash = h2;
  end
endmodule

### src/ikhm_store.sv
// entry key and value memories, one read and one write port each
module ikhm_store #(
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_key,
  output logic [31:0]   rd_value,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_key,
  input  logic [31:0]   wr_value
);
  logic [31:0] keys   [2**AW];
  logic [31:0] values [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys[wr_addr]   <= wr_key;
      values[wr_addr] <= wr_value;
    end
    rd_key   <= keys[rd_addr];
    rd_value <= values[rd_addr];
  end
endmodule

### src/int_key_hash_map_sorted_buckets_core.sv
// top level of the sorted-bucket integer map
//
// Requests enter on the s_axis group: tdata holds operation, key and value.
// Each request gives one result on m_axis: status, found value and the
// total entry count after the operation.
// A request hashes its key, reads its bucket fill from the fill memory,
// then walks its bucket slot by slot through the entry memory to find
// the match or insertion point.
// Inserts shift the tail up and deletes shift it down, slot by slot.
// One request is worked at a time; the next is taken once the core is
// idle again, and not while a result is stalled.
// After reset the fill memory is cleared one bucket a cycle, with
// s_axis_tready low throughout; the entry memory itself is not cleared.
// A stalled result holds until taken and blocks new requests meanwhile.
module int_key_hash_map_sorted_buckets_core import ikhm_pkg::*; #(
  parameter int NUM_BUCKETS  = 64,
  parameter int BUCKET_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[1:0], key[33:2], value[65:34], zero fill to 72 bits
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], found_value[33:2], entry_count[43:34], zero fill to 48 bits
  output logic [47:0] m_axis_tdata
);
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FW = $clog2(BUCKET_DEPTH + 1);
  localparam int AW = $clog2(NUM_BUCKETS * BUCKET_DEPTH) > 0 ?
                      $clog2(NUM_BUCKETS * BUCKET_DEPTH) : 1;
  localparam logic [FW-1:0] DEPTH_F = FW'(BUCKET_DEPTH);

  state_t state, state_next;

  logic [1:0]  op;
  logic [31:0] key;
  logic [31:0] value;
  logic [BW-1:0] bucket;
  logic [FW-1:0] fill;
  logic [FW-1:0] idx;
  logic [FW-1:0] pos;
  logic          hit;
  logic [9:0]    total;
  logic [FW-1:0] fills [NUM_BUCKETS];
  logic [FW-1:0] fill_rd;
  logic [BW-1:0] clr_addr;
  logic [BW-1:0] hash_bucket;
  logic          fill_wr_en;
  logic [BW-1:0] fill_wr_addr;
  logic [FW-1:0] fill_wr_data;

  logic          out_valid;
  logic [1:0]    out_status;
  logic [31:0]   out_found;

  logic [31:0]   hash;
  logic [31:0]   rd_key, rd_value;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [31:0]   wr_key, wr_value;

  ikhm_hash u_hash (
    .clk   (clk),
    .start (s_axis_tvalid && s_axis_tready),
    .key   (s_axis_tdata[33:2]),
    .hash  (hash)
  );

  ikhm_store #(.AW(AW)) u_store (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_value (rd_value),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_value (wr_value)
  );

  function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b,
                                               input logic [FW-1:0] s);
    slot_addr = AW'(b * BUCKET_DEPTH + s);
  endfunction

  assign hash_bucket   = BW'(hash % NUM_BUCKETS);
  assign s_axis_tready = (state == S_IDLE) && !(out_valid && !m_axis_tready);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, total, out_found, out_status};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:     if (clr_addr == BW'(NUM_BUCKETS - 1)) state_next = S_IDLE;
      S_IDLE:      if (s_axis_tvalid && s_axis_tready) state_next = S_HASH2;
      S_HASH2:     state_next = S_HASH3;
      S_HASH3:     state_next = S_FILL_WAIT;
      S_FILL_WAIT: state_next = S_SCAN;
      S_SCAN:      state_next = (idx < fill) ? S_SCAN_WAIT : S_DECIDE;
      S_SCAN_WAIT: begin
        if (!key_less(key, rd_key) && (key != rd_key)) state_next = S_SCAN;
        else state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (op[1]) state_next = (hit && op == OP_DELETE) ? S_SHIFT_RD : S_DONE;
        else if (!hit && fill < DEPTH_F) state_next = S_SHIFT_RD;
        else state_next = S_DONE;
      end
      S_SHIFT_RD:  state_next = S_SHIFT_WR;
      S_SHIFT_WR:  state_next = S_SHIFT_RD;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
    // shift finishes once the cursor reaches its end point
    if (state == S_SHIFT_RD) begin
      if (op == OP_DELETE ? (idx + 1'b1 >= fill) : (idx <= pos)) state_next = S_DONE;
    end
  end

  // memory access selection
  always_comb begin
    rd_addr  = slot_addr(bucket, idx);
    wr_en    = 1'b0;
    wr_addr  = slot_addr(bucket, idx);
    wr_key   = rd_key;
    wr_value = rd_value;
    case (state)
      S_SHIFT_RD: begin
        if (op == OP_DELETE) rd_addr = slot_addr(bucket, idx + 1'b1);
        else rd_addr = slot_addr(bucket, idx - 1'b1);
        if (op == OP_DELETE ? (idx + 1'b1 >= fill) : (idx <= pos)) begin
          wr_en = !(op == OP_DELETE);
          wr_key = key;
          wr_value = value;
        end
      end
      S_SHIFT_WR: wr_en = 1'b1;
      S_DECIDE: begin
        if (hit && op == OP_PUT) begin
          wr_en = 1'b1;
          wr_addr = slot_addr(bucket, pos);
          wr_key = key;
          wr_value = value;
        end
      end
      default: ;
    endcase
  end

  // fill memory write: clearing pass, then the new fill at the end of a shift
  always_comb begin
    fill_wr_en   = 1'b0;
    fill_wr_addr = bucket;
    fill_wr_data = fill;
    case (state)
      S_CLEAR: begin
        fill_wr_en   = 1'b1;
        fill_wr_addr = clr_addr;
        fill_wr_data = '0;
      end
      S_SHIFT_RD: begin
        if (op == OP_DELETE ? (idx + 1'b1 >= fill) : (idx <= pos)) begin
          fill_wr_en   = 1'b1;
          fill_wr_data = (op == OP_DELETE) ? fill - 1'b1 : fill + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // bucket fill memory, with a registered read at the hashed bucket
  always_ff @(posedge clk) begin
    if (fill_wr_en) fills[fill_wr_addr] <= fill_wr_data;
    fill_rd <= fills[hash_bucket];
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      total     <= '0;
    end else begin
      state <= state_next;
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: clr_addr <= clr_addr + 1'b1;
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          op    <= s_axis_tdata[1:0];
          key   <= s_axis_tdata[33:2];
          value <= s_axis_tdata[65:34];
          idx   <= '0;
          hit   <= 1'b0;
        end
        S_HASH3: bucket <= hash_bucket;
        S_FILL_WAIT: fill <= (fill_rd > DEPTH_F) ? DEPTH_F : fill_rd;
        S_SCAN: if (!(idx < fill)) pos <= fill;
        S_SCAN_WAIT: begin
          if (key == rd_key) begin
            hit <= 1'b1;
            pos <= idx;
          end else if (key_less(key, rd_key)) begin
            pos <= idx;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DECIDE: begin
          out_found  <= '0;
          out_status <= ST_OK;
          if (op[1]) begin
            if (!hit) out_status <= ST_MISSING;
            else if (op == OP_FIND) out_found <= rd_value;
            else idx <= pos;
          end else if (hit) begin
            if (op == OP_UNIQUE) out_status <= ST_EXISTS;
          end else if (fill >= DEPTH_F) begin
            out_status <= ST_FULL;
          end else begin
            idx <= fill;
          end
        end
        S_SHIFT_RD: begin
          if (op == OP_DELETE ? (idx + 1'b1 >= fill) : (idx <= pos)) begin
            if (op == OP_DELETE) begin
              if (total != 0) total <= total - 1'b1;
            end else begin
              total <= total + 1'b1;
            end
          end
        end
        S_SHIFT_WR: idx <= (op == OP_DELETE) ? idx + 1'b1 : idx - 1'b1;
        S_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // a result is never overwritten while it waits
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |=> (out_valid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");
  // no request is taken while a result is stalled
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |-> !s_axis_tready)
    else $error("request taken while stalled");
  // a bucket fill never exceeds its depth
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (fill <= DEPTH_F))
    else $error("bucket fill out of range");
endmodule

### tb/ikhm_checker.sv
// checker for the sorted-bucket integer map: predicts each result and compares it
module ikhm_checker import ikhm_pkg::*; #(
  parameter int NUM_BUCKETS  = 64,
  parameter int BUCKET_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t     status;
    logic [31:0] found_value;
    logic [9:0]  entry_count;
  } map_result_t;

  // shadow copy of the map contents
  logic [31:0] shadow_keys [NUM_BUCKETS*BUCKET_DEPTH];
  logic [31:0] shadow_vals [NUM_BUCKETS*BUCKET_DEPTH];
  int          shadow_fill [NUM_BUCKETS];
  int          shadow_total;
  map_result_t expected_results [$];

  function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic int bucket_of(input logic [31:0] k);
    logic [31:0] h;
    h = (k ^ 32'd61) ^ sra32(k, 16);
    h = h + (h << 3);
    h = h ^ sra32(h, 4);
    h = h * 32'h27d4eb2d;
    h = h ^ sra32(h, 15);
    return int'(h % NUM_BUCKETS);
  endfunction

  // apply one request to the shadow map and return the expected result
  function automatic map_result_t apply_request(input op_t op, input logic [31:0] key,
                                                input logic [31:0] val);
    map_result_t r;
    int b, base, fill, pos, lo, hi, mid, idx;
    logic hit;
    b = bucket_of(key);
    base = b * BUCKET_DEPTH;
    fill = shadow_fill[b];
    r.status = ST_OK;
    r.found_value = '0;
    if (op == OP_PUT || op == OP_UNIQUE) begin
      pos = fill;
      hit = 1'b0;
      for (int i = 0; i < fill; i++) begin
        if (shadow_keys[base+i] == key) begin
          hit = 1'b1; pos = i; break;
        end
        if ($signed(key) < $signed(shadow_keys[base+i])) begin
          pos = i; break;
        end
      end
      if (hit) begin
        if (op == OP_PUT) shadow_vals[base+pos] = val;
        else r.status = ST_EXISTS;
      end else if (fill >= BUCKET_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (int i = fill; i > pos; i--) begin
          shadow_keys[base+i] = shadow_keys[base+i-1];
          shadow_vals[base+i] = shadow_vals[base+i-1];
        end
        shadow_keys[base+pos] = key;
        shadow_vals[base+pos] = val;
        shadow_fill[b] = fill + 1;
        shadow_total++;
      end
    end else begin
      lo = 0; hi = fill; idx = -1;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (key == shadow_keys[base+mid]) begin
          idx = mid; break;
        end
        if ($signed(key) > $signed(shadow_keys[base+mid])) lo = mid + 1;
        else hi = mid;
      end
      if (idx < 0) begin
        r.status = ST_MISSING;
      end else if (op == OP_FIND) begin
        r.found_value = shadow_vals[base+idx];
      end else begin
        for (int i = idx; i + 1 < fill; i++) begin
          shadow_keys[base+i] = shadow_keys[base+i+1];
          shadow_vals[base+i] = shadow_vals[base+i+1];
        end
        shadow_fill[b] = fill - 1;
        if (shadow_total > 0) shadow_total--;
      end
    end
    r.entry_count = shadow_total[9:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    shadow_total = 0;
    foreach (shadow_fill[i]) shadow_fill[i] = 0;
  end

  assign pending_count = expected_results.size();

  // watch both channels at each rising edge
  always @(posedge clk) begin
    map_result_t exp_r;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(apply_request(op_t'(s_axis_tdata[1:0]),
                                                 s_axis_tdata[33:2], s_axis_tdata[65:34]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
        end else begin
          exp_r = expected_results.pop_front();
          if (m_axis_tdata[1:0] != exp_r.status)
            report_mismatch("status", m_axis_tdata[1:0], exp_r.status);
          if (m_axis_tdata[33:2] != exp_r.found_value)
            report_mismatch("found_value", m_axis_tdata[33:2], exp_r.found_value);
          if (m_axis_tdata[43:34] != exp_r.entry_count)
            report_mismatch("entry_count", m_axis_tdata[43:34], exp_r.entry_count);
        end
      end
    end
  end

endmodule

### tb/tb_top.sv
// testbench top for the sorted-bucket integer map: stimulus and verdict
module tb_top import ikhm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  int          fail_count;
  int          pending_count;
  logic        stimulus_done = 1'b0;
  int          idle_cycles = 0;
  logic [31:0] key_pool [16];

  int_key_hash_map_sorted_buckets_core dut (.*);

  ikhm_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // send one request, holding it until accepted
  task automatic send_request(input op_t op, input logic [31:0] key, input logic [31:0] val);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  <= {6'd0, val, key, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // bucket of a key from the checker's hash model, used to find keys that share a bucket
  function automatic int bucket_of_key(input logic [31:0] k);
    return checker_i.bucket_of(k);
  endfunction

  // receiver: random stalls, one long hold-off early on
  initial begin
    int wait_cycles;
    repeat (7) @(negedge clk);
    repeat (40) @(negedge clk);
    m_axis_tready <= 1'b0;
    repeat (300) @(negedge clk);
    forever begin
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    logic [31:0] k, v;
    int n, target;
    op_t op;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed: extreme keys and values, every operation
    send_request(OP_FIND,   32'h8000_0000, 32'h0);
    send_request(OP_PUT,    32'h8000_0000, 32'hffff_ffff);
    send_request(OP_PUT,    32'h7fff_ffff, 32'h0);
    send_request(OP_PUT,    32'h0,         32'hffff_ffff);
    send_request(OP_PUT,    32'hffff_ffff, 32'ha5a5_5a5a);
    send_request(OP_UNIQUE, 32'h8000_0000, 32'h1234_5678);
    send_request(OP_PUT,    32'h8000_0000, 32'h5a5a_a5a5);
    send_request(OP_FIND,   32'h8000_0000, 32'h0);
    send_request(OP_FIND,   32'h7fff_ffff, 32'hffff_ffff);
    send_request(OP_DELETE, 32'h0,         32'h0);
    send_request(OP_DELETE, 32'h0,         32'h0);
    send_request(OP_FIND,   32'hffff_ffff, 32'h0);
    // fill one bucket past its depth: full, replace in full, unique in full
    target = bucket_of_key(32'd5);
    n = 0;
    k = 32'd5;
    while (n < 10) begin
      if (bucket_of_key(k) == target) begin
        send_request(OP_UNIQUE, k, k ^ 32'hdead_beef);
        n++;
      end
      k = k + 32'd7919;
    end
    send_request(OP_PUT,    32'd5, 32'h1111_1111);
    send_request(OP_FIND,   32'd5, 32'h0);
    send_request(OP_DELETE, 32'd5, 32'h0);
    // random: mostly keys from a small pool so hits, fills and deletes occur
    foreach (key_pool[i]) key_pool[i] = $urandom();
    for (int i = 0; i < 1100; i++) begin
      if ($urandom_range(0, 9) < 7) k = key_pool[$urandom_range(0, 15)] + $urandom_range(0, 15) * 32'h0001_0003;
      else k = $urandom();
      v = $urandom();
      op = op_t'($urandom_range(0, 3));
      send_request(op, k, v);
    end
    s_axis_tvalid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("int_key_hash_map_sorted_buckets_core test failed");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && !m_axis_tvalid)
      $display("int_key_hash_map_sorted_buckets_core test passed");
    else
      $display("int_key_hash_map_sorted_buckets_core test failed");
    $finish;
  end

endmodule

### int_key_hash_map_sorted_buckets_core.f
src/ikhm_pkg.sv
src/ikhm_hash.sv
src/ikhm_store.sv
src/int_key_hash_map_sorted_buckets_core.sv
tb/ikhm_checker.sv
tb/tb_top.sv
